### rtl/bpa_pkg.sv
package bpa_pkg;

    // widths fixed by the item format
    localparam int FW    = 21;  // frame arithmetic: 20-bit base plus page offset
    localparam int PG_W  = 12;
    localparam int ORD_W = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_FREE = 2'd1;
    localparam logic [1:0] STAT_BAD     = 2'd2;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_PCNT = 1'b1;

    typedef struct packed {
        logic             action;
        logic [ORD_W-1:0] order;
        logic [PG_W-1:0]  page_index;
        logic             bad;
    } t_req;

    typedef struct packed {
        logic clearing;
    } t_bk_stat;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_TRD,
        ST_TWR,
        ST_PUT_A,
        ST_PUT_B,
        ST_SSTEP,
        ST_MSTEP
    } t_state;

    typedef enum logic [2:0] {
        JOB_POP,
        JOB_SPLIT,
        JOB_CHK,
        JOB_MERGE,
        JOB_FINAL
    } t_job;

endpackage

### rtl/bpa_ram.sv
module bpa_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_wa,
    input  logic [W-1:0]         i_wd,
    input  logic [$clog2(D)-1:0] i_ra,
    output logic [W-1:0]         o_rd
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end

endmodule

### rtl/bpa_front.sv
module bpa_front #(
    parameter int ORDERS = 11
) (
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_action,
    input  logic [bpa_pkg::ORD_W-1:0]  i_order,
    input  logic [bpa_pkg::PG_W-1:0]   i_page_index,
    input  logic [bpa_pkg::FW-1:0]     i_seg,
    input  bpa_pkg::t_bk_stat          i_stat,
    input  logic                       i_q_full,
    output logic                       o_push,
    output bpa_pkg::t_req              o_req
);

    logic [bpa_pkg::FW-1:0] s_end;
    logic                   s_bad;

    // block end must stay inside the segment for a release
    assign s_end = bpa_pkg::FW'(i_page_index) + (bpa_pkg::FW'(1) << i_order);
    assign s_bad = ({1'b0, i_order} >= 5'(ORDERS))
                || ((i_action == bpa_pkg::ACT_RELEASE) && (s_end > i_seg));

    assign o_ready = !i_q_full && !i_stat.clearing;
    assign o_push  = i_valid && o_ready;

    assign o_req.action     = i_action;
    assign o_req.order      = i_order;
    assign o_req.page_index = i_page_index;
    assign o_req.bad        = s_bad;

endmodule

### rtl/bpa_queue.sv
module bpa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bpa_pkg::t_req i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output bpa_pkg::t_req o_data
);

    localparam int QA = (bpa_pkg::QUEUE_DEPTH > 1) ? $clog2(bpa_pkg::QUEUE_DEPTH) : 1;
    localparam int QC = $clog2(bpa_pkg::QUEUE_DEPTH + 1);

    bpa_pkg::t_req r_mem [bpa_pkg::QUEUE_DEPTH];
    logic [QA-1:0] r_wp, r_rp;
    logic [QC-1:0] r_cnt;

    assign o_full  = (r_cnt == QC'(bpa_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QA'(bpa_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QA'(bpa_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### rtl/bpa_back.sv
module bpa_back #(
    parameter int PAGES  = 4096,
    parameter int ORDERS = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    input  bpa_pkg::t_req             i_req,
    output logic                      o_req_pop,
    input  logic [bpa_pkg::FW-1:0]    i_base,
    input  logic [bpa_pkg::FW-1:0]    i_seg,
    output bpa_pkg::t_bk_stat         o_stat,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_status,
    output logic [bpa_pkg::PG_W-1:0]  o_block_page,
    output logic [bpa_pkg::ORD_W-1:0] o_final_order
);

    localparam int AW = $clog2(PAGES);
    localparam int LW = $clog2(PAGES + 1);
    localparam int TW = $clog2(ORDERS + 1);
    localparam int OI = (ORDERS > 1) ? $clog2(ORDERS) : 1;
    localparam int FW = bpa_pkg::FW;
    localparam int OW = bpa_pkg::ORD_W;
    localparam int PW = bpa_pkg::PG_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(PAGES);
    localparam logic [TW-1:0] NOT_FREE  = TW'(ORDERS);

    bpa_pkg::t_state r_state, n_state;
    bpa_pkg::t_job   r_job, n_job;
    logic            r_alloc, n_alloc;
    logic            r_stop, n_stop;
    logic [AW-1:0]   r_addr, n_addr;
    logic [AW-1:0]   r_blk, n_blk;
    logic [OW-1:0]   r_o, n_o;
    logic [OW-1:0]   r_ord, n_ord;
    logic [FW-1:0]   r_frame, n_frame;
    logic [LW-1:0]   r_lnk, n_lnk;
    logic [AW-1:0]   r_clr, n_clr;
    logic [LW-1:0]   r_head [ORDERS];
    logic [LW-1:0]   r_tail [ORDERS];
    logic [LW-1:0]   n_head [ORDERS];
    logic [LW-1:0]   n_tail [ORDERS];
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_out_status, n_out_status;
    logic [PW-1:0]   r_out_page, n_out_page;
    logic [OW-1:0]   r_out_fin, n_out_fin;

    logic            tag_we, nxt_we, prv_we;
    logic [AW-1:0]   tag_wa, nxt_wa, prv_wa;
    logic [TW-1:0]   tag_wd, tag_rd;
    logic [LW-1:0]   nxt_wd, nxt_rd, prv_wd, prv_rd;

    logic            s_found;
    logic [OW-1:0]   s_o;
    logic [LW-1:0]   s_head_pg;
    logic [FW-1:0]   s_bf, s_bi, s_fidx;
    logic            s_bf_ok;
    logic [OW:0]     s_ord_inc;
    logic            s_can_merge;
    logic [OW-1:0]   s_o_dec;
    logic [AW:0]     s_b_full;
    logic            s_b_in;
    logic            s_do_take;
    logic [OW-1:0]   s_po;
    logic [OI-1:0]   s_pidx, s_tidx;
    logic            s_put_tail;
    logic [LW-1:0]   s_put_lnk, s_addr_lnk;

    bpa_ram #(.W(TW), .D(PAGES)) u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_wa(tag_wa), .i_wd(tag_wd),
        .i_ra(r_addr), .o_rd(tag_rd)
    );
    bpa_ram #(.W(LW), .D(PAGES)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_wa(nxt_wa), .i_wd(nxt_wd),
        .i_ra(r_addr), .o_rd(nxt_rd)
    );
    bpa_ram #(.W(LW), .D(PAGES)) u_prv (
        .i_clk(i_clk), .i_we(prv_we), .i_wa(prv_wa), .i_wd(prv_wd),
        .i_ra(r_addr), .o_rd(prv_rd)
    );

    // lowest non-empty list at or above the requested order
    always_comb begin
        s_found = 1'b0;
        s_o     = '0;
        for (int k = ORDERS - 1; k >= 0; k--) begin
            if ((k >= int'(i_req.order)) && (r_head[k] != NULL_LINK)) begin
                s_found = 1'b1;
                s_o     = OW'(k);
            end
        end
    end
    assign s_head_pg = r_head[s_o[OI-1:0]];

    assign s_bf        = r_frame ^ (FW'(1) << r_ord);
    assign s_bi        = s_bf - i_base;
    assign s_bf_ok     = (s_bf >= i_base) && (s_bi < i_seg);
    assign s_ord_inc   = {1'b0, r_ord} + 1'b1;
    assign s_can_merge = s_ord_inc < (OW+1)'(ORDERS);
    assign s_fidx      = r_frame - i_base;
    assign s_o_dec     = r_o - 1'b1;
    assign s_b_full    = (AW+1)'(r_blk) + ((AW+1)'(1) << s_o_dec);
    assign s_b_in      = s_b_full < (AW+1)'(PAGES);
    assign s_tidx      = tag_rd[OI-1:0];
    assign s_do_take   = (tag_rd < NOT_FREE) && (r_job != bpa_pkg::JOB_CHK)
                      && ((r_job != bpa_pkg::JOB_MERGE) || (tag_rd == TW'(r_ord)));
    assign s_put_tail  = !r_alloc;
    assign s_po        = r_alloc ? r_o : r_ord;
    assign s_pidx      = s_po[OI-1:0];
    assign s_put_lnk   = s_put_tail ? r_tail[s_pidx] : r_head[s_pidx];
    assign s_addr_lnk  = LW'(r_addr);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpa_pkg::ST_CLR: begin
                if (r_clr == AW'(PAGES - 1)) begin
                    n_state = bpa_pkg::ST_IDLE;
                end
            end
            bpa_pkg::ST_IDLE: begin
                if (i_req_valid && !r_out_valid && !i_req.bad) begin
                    if (i_req.action == bpa_pkg::ACT_RELEASE || s_found) begin
                        n_state = bpa_pkg::ST_TRD;
                    end
                end
            end
            bpa_pkg::ST_TRD: n_state = bpa_pkg::ST_TWR;
            bpa_pkg::ST_TWR: begin
                priority case (r_job)
                    bpa_pkg::JOB_POP: n_state = bpa_pkg::ST_SSTEP;
                    bpa_pkg::JOB_CHK: begin
                        n_state = (tag_rd < NOT_FREE) ? bpa_pkg::ST_IDLE : bpa_pkg::ST_MSTEP;
                    end
                    bpa_pkg::JOB_MERGE: n_state = bpa_pkg::ST_MSTEP;
                    default: n_state = bpa_pkg::ST_PUT_A;
                endcase
            end
            bpa_pkg::ST_PUT_A: n_state = bpa_pkg::ST_PUT_B;
            bpa_pkg::ST_PUT_B: begin
                n_state = r_alloc ? bpa_pkg::ST_SSTEP : bpa_pkg::ST_IDLE;
            end
            bpa_pkg::ST_SSTEP: begin
                if (r_o > r_ord) begin
                    if (s_b_in) begin
                        n_state = bpa_pkg::ST_TRD;
                    end
                end else begin
                    n_state = bpa_pkg::ST_IDLE;
                end
            end
            bpa_pkg::ST_MSTEP: begin
                if ((!r_stop && s_can_merge && s_bf_ok) || (s_fidx < FW'(PAGES))) begin
                    n_state = bpa_pkg::ST_TRD;
                end else begin
                    n_state = bpa_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // datapath and memory ports
    always_comb begin
        n_job        = r_job;
        n_alloc      = r_alloc;
        n_stop       = r_stop;
        n_addr       = r_addr;
        n_blk        = r_blk;
        n_o          = r_o;
        n_ord        = r_ord;
        n_frame      = r_frame;
        n_lnk        = r_lnk;
        n_clr        = r_clr;
        n_head       = r_head;
        n_tail       = r_tail;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_page   = r_out_page;
        n_out_fin    = r_out_fin;
        o_req_pop    = 1'b0;
        tag_we = 1'b0; tag_wa = r_addr; tag_wd = NOT_FREE;
        nxt_we = 1'b0; nxt_wa = r_addr; nxt_wd = NULL_LINK;
        prv_we = 1'b0; prv_wa = r_addr; prv_wd = NULL_LINK;

        unique case (r_state)
            bpa_pkg::ST_CLR: begin
                tag_we = 1'b1;
                tag_wa = r_clr;
                n_clr  = r_clr + 1'b1;
            end
            bpa_pkg::ST_IDLE: begin
                if (i_req_valid && !r_out_valid) begin
                    o_req_pop = 1'b1;
                    n_alloc   = (i_req.action == bpa_pkg::ACT_ALLOC);
                    n_ord     = i_req.order;
                    n_stop    = 1'b0;
                    if (i_req.bad) begin
                        n_out_valid  = 1'b1;
                        n_out_status = bpa_pkg::STAT_BAD;
                        n_out_page   = '0;
                        n_out_fin    = '0;
                    end else if (i_req.action == bpa_pkg::ACT_ALLOC) begin
                        if (s_found) begin
                            n_blk  = s_head_pg[AW-1:0];
                            n_addr = s_head_pg[AW-1:0];
                            n_o    = s_o;
                            n_job  = bpa_pkg::JOB_POP;
                        end else begin
                            n_out_valid  = 1'b1;
                            n_out_status = bpa_pkg::STAT_NO_FREE;
                            n_out_page   = '0;
                            n_out_fin    = '0;
                        end
                    end else begin
                        n_addr  = AW'(i_req.page_index);
                        n_frame = i_base + FW'(i_req.page_index);
                        n_job   = bpa_pkg::JOB_CHK;
                    end
                end
            end
            bpa_pkg::ST_TRD: begin
            end
            bpa_pkg::ST_TWR: begin
                // unlink the page just read from its list
                if (s_do_take) begin
                    if (prv_rd != NULL_LINK) begin
                        nxt_we = 1'b1;
                        nxt_wa = prv_rd[AW-1:0];
                        nxt_wd = nxt_rd;
                    end else begin
                        n_head[s_tidx] = nxt_rd;
                    end
                    if (nxt_rd != NULL_LINK) begin
                        prv_we = 1'b1;
                        prv_wa = nxt_rd[AW-1:0];
                        prv_wd = prv_rd;
                    end else begin
                        n_tail[s_tidx] = prv_rd;
                    end
                    tag_we = 1'b1;
                end
                if (r_job == bpa_pkg::JOB_CHK) begin
                    if (tag_rd < NOT_FREE) begin
                        // double release
                        n_out_valid  = 1'b1;
                        n_out_status = bpa_pkg::STAT_BAD;
                        n_out_page   = '0;
                        n_out_fin    = '0;
                    end
                end else if (r_job == bpa_pkg::JOB_MERGE) begin
                    if (tag_rd == TW'(r_ord)) begin
                        n_ord   = s_ord_inc[OW-1:0];
                        n_frame = r_frame & ~((FW'(1) << s_ord_inc) - 1'b1);
                    end else begin
                        n_stop = 1'b1;
                    end
                end
            end
            bpa_pkg::ST_PUT_A: begin
                n_lnk  = s_put_lnk;
                tag_we = 1'b1;
                tag_wd = TW'(s_po);
                nxt_we = 1'b1;
                prv_we = 1'b1;
                if (s_put_tail) begin
                    prv_wd = s_put_lnk;
                    n_tail[s_pidx] = s_addr_lnk;
                    if (s_put_lnk == NULL_LINK) begin
                        n_head[s_pidx] = s_addr_lnk;
                    end
                end else begin
                    nxt_wd = s_put_lnk;
                    n_head[s_pidx] = s_addr_lnk;
                    if (s_put_lnk == NULL_LINK) begin
                        n_tail[s_pidx] = s_addr_lnk;
                    end
                end
            end
            bpa_pkg::ST_PUT_B: begin
                // back link from the old tail or head
                if (r_lnk != NULL_LINK) begin
                    if (s_put_tail) begin
                        nxt_we = 1'b1;
                        nxt_wa = r_lnk[AW-1:0];
                        nxt_wd = s_addr_lnk;
                    end else begin
                        prv_we = 1'b1;
                        prv_wa = r_lnk[AW-1:0];
                        prv_wd = s_addr_lnk;
                    end
                end
                if (!r_alloc) begin
                    n_out_valid  = 1'b1;
                    n_out_status = bpa_pkg::STAT_OK;
                    n_out_page   = PW'(r_addr);
                    n_out_fin    = r_ord;
                end
            end
            bpa_pkg::ST_SSTEP: begin
                if (r_o > r_ord) begin
                    n_o = s_o_dec;
                    if (s_b_in) begin
                        n_addr = s_b_full[AW-1:0];
                        n_job  = bpa_pkg::JOB_SPLIT;
                    end
                end else begin
                    n_out_valid  = 1'b1;
                    n_out_status = bpa_pkg::STAT_OK;
                    n_out_page   = PW'(r_blk);
                    n_out_fin    = '0;
                end
            end
            bpa_pkg::ST_MSTEP: begin
                if (!r_stop && s_can_merge && s_bf_ok) begin
                    n_addr = s_bi[AW-1:0];
                    n_job  = bpa_pkg::JOB_MERGE;
                end else if (s_fidx < FW'(PAGES)) begin
                    n_addr = s_fidx[AW-1:0];
                    n_job  = bpa_pkg::JOB_FINAL;
                end else begin
                    n_out_valid  = 1'b1;
                    n_out_status = bpa_pkg::STAT_OK;
                    n_out_page   = PW'(s_fidx);
                    n_out_fin    = r_ord;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpa_pkg::ST_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < ORDERS; k++) begin
                r_head[k] <= NULL_LINK;
                r_tail[k] <= NULL_LINK;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job        <= n_job;
        r_alloc      <= n_alloc;
        r_stop       <= n_stop;
        r_addr       <= n_addr;
        r_blk        <= n_blk;
        r_o          <= n_o;
        r_ord        <= n_ord;
        r_frame      <= n_frame;
        r_lnk        <= n_lnk;
        r_out_status <= n_out_status;
        r_out_page   <= n_out_page;
        r_out_fin    <= n_out_fin;
    end

    assign o_stat.clearing = (r_state == bpa_pkg::ST_CLR);
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_block_page    = r_out_page;
    assign o_final_order   = r_out_fin;

endmodule

### rtl/buddy_page_allocator_unit.sv
// Buddy page allocator over one segment of pages, one free list per order.
// Request channel (i_valid/o_ready): action, order, page_index. A transfer
// takes place on a rising edge with both high. Response channel
// (o_valid/i_ready): status, block_page, final_order, one per request, in
// request order.
// Configuration: i_cfg_we writes base_frame (index 0) or page_count
// (index 1) on the same edge; write only while the block is idle.
// Flow: a bad request or an allocate with nothing free is answered from
// the idle state. Allocate pops the head block, then splits it one
// level at a time; release checks the page tag, merges with the buddy
// level by level and then links the block onto its list. Each step goes
// through the tag and link memories. Items are worked one at a time.
// A two-entry queue sits between the request decode and the list engine,
// and a result register sits at the output, so a stalled receiver holds
// only the result register while new requests still queue up.
// Reset (synchronous, active low) empties all lists and then runs a
// clearing pass over the page tags with o_ready low.
module buddy_page_allocator_unit #(
    parameter int PAGES  = 4096,
    parameter int ORDERS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [3:0]  i_order,
    input  logic [11:0] i_page_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [11:0] o_block_page,
    output logic [3:0]  o_final_order,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [19:0] i_cfg_data
);

    logic [19:0]            r_base;
    logic [12:0]            r_pcnt;
    logic [bpa_pkg::FW-1:0] s_base, s_pcnt, s_seg;

    bpa_pkg::t_req     s_req_in, s_req_out;
    bpa_pkg::t_bk_stat s_stat;
    logic              s_push, s_full, s_q_valid, s_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_pcnt <= 13'd4096;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bpa_pkg::CFG_BASE) begin
                r_base <= i_cfg_data;
            end else begin
                r_pcnt <= i_cfg_data[12:0];
            end
        end
    end

    // page counts above PAGES act as PAGES
    assign s_base = bpa_pkg::FW'(r_base);
    assign s_pcnt = bpa_pkg::FW'(r_pcnt);
    assign s_seg  = (s_pcnt < bpa_pkg::FW'(PAGES)) ? s_pcnt : bpa_pkg::FW'(PAGES);

    bpa_front #(.ORDERS(ORDERS)) u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_order      (i_order),
        .i_page_index (i_page_index),
        .i_seg        (s_seg),
        .i_stat       (s_stat),
        .i_q_full     (s_full),
        .o_push       (s_push),
        .o_req        (s_req_in)
    );

    bpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_req_in),
        .o_full  (s_full),
        .i_pop   (s_pop),
        .o_valid (s_q_valid),
        .o_data  (s_req_out)
    );

    bpa_back #(.PAGES(PAGES), .ORDERS(ORDERS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_q_valid),
        .i_req         (s_req_out),
        .o_req_pop     (s_pop),
        .i_base        (s_base),
        .i_seg         (s_seg),
        .o_stat        (s_stat),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_block_page  (o_block_page),
        .o_final_order (o_final_order)
    );

endmodule

### rtl/bpa_checker.sv
module bpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [11:0] o_block_page,
    input logic [3:0]  o_final_order
);

    // response held while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_block_page)
                                && $stable(o_final_order))
        else $error("response changed under stall");

    a_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != bpa_pkg::STAT_OK) |-> (o_block_page == 12'd0)
                                                   && (o_final_order == 4'd0))
        else $error("fields set on failed request");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == bpa_pkg::STAT_OK) || (o_status == bpa_pkg::STAT_NO_FREE)
                    || (o_status == bpa_pkg::STAT_BAD))
        else $error("undefined status code");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("response after reset");

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_block_page  (o_block_page),
    .o_final_order (o_final_order)
);

### test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPAGES  = 4096;
    localparam int NORDERS = 11;
    localparam int NIL     = NPAGES;

    // Allocator state kept by the testbench, used to work out each response.
    class buddy_board;
        int unsigned tag [NPAGES];
        int unsigned nxt [NPAGES];
        int unsigned prv [NPAGES];
        int unsigned head [NORDERS];
        int unsigned tail [NORDERS];
        int unsigned cnt [NORDERS];
        int unsigned base_frame;
        int unsigned page_count;
        logic [1:0]  exp_status [$];
        logic [11:0] exp_page [$];
        logic [3:0]  exp_order [$];
        int errors;

        function new();
            errors = 0;
            base_frame = 0;
            page_count = 4096;
            for (int i = 0; i < NPAGES; i++) begin
                tag[i] = NORDERS;
                nxt[i] = NIL;
                prv[i] = NIL;
            end
            for (int i = 0; i < NORDERS; i++) begin
                head[i] = NIL;
                tail[i] = NIL;
                cnt[i] = 0;
            end
        endfunction

        function void set_reg(logic idx, logic [19:0] v);
            if (idx == bpa_pkg::CFG_BASE) base_frame = v;
            else page_count = v[12:0];
        endfunction

        function void unlink(int unsigned pg);
            int unsigned o, p, n;
            o = tag[pg];
            if (o >= NORDERS) return;
            p = prv[pg];
            n = nxt[pg];
            if (p < NPAGES) nxt[p] = n; else head[o] = n;
            if (n < NPAGES) prv[n] = p; else tail[o] = p;
            if (cnt[o] > 0) cnt[o]--;
            nxt[pg] = NIL;
            prv[pg] = NIL;
            tag[pg] = NORDERS;
        endfunction

        function void link(int unsigned pg, int unsigned o, bit at_tail);
            int unsigned t;
            unlink(pg);
            if (at_tail) begin
                t = tail[o];
                prv[pg] = t;
                nxt[pg] = NIL;
                if (t < NPAGES) nxt[t] = pg; else head[o] = pg;
                tail[o] = pg;
            end else begin
                t = head[o];
                nxt[pg] = t;
                prv[pg] = NIL;
                if (t < NPAGES) prv[t] = pg; else tail[o] = pg;
                head[o] = pg;
            end
            tag[pg] = o;
            cnt[o]++;
        endfunction

        // note an accepted request and queue its expected response
        function void note_request(logic act, logic [3:0] ord_in, logic [11:0] pidx);
            int unsigned st, blk, fin, ord, idx, seg, frame, bf, h, o, b;
            st = bpa_pkg::STAT_BAD; blk = 0; fin = 0;
            ord = ord_in; idx = pidx;
            if (ord < NORDERS) begin
                if (act == bpa_pkg::ACT_ALLOC) begin
                    st = bpa_pkg::STAT_NO_FREE;
                    for (o = ord; o < NORDERS; o++) begin
                        h = head[o];
                        if (h < NPAGES) begin
                            unlink(h);
                            while (o > ord) begin
                                o--;
                                b = h + (1 << o);
                                if (b < NPAGES) link(b, o, 0);
                            end
                            st = bpa_pkg::STAT_OK;
                            blk = h;
                            break;
                        end
                    end
                end else begin
                    seg = page_count < NPAGES ? page_count : NPAGES;
                    if (idx + (1 << ord) <= seg && tag[idx] >= NORDERS) begin
                        frame = base_frame + idx;
                        while (ord + 1 < NORDERS) begin
                            bf = frame ^ (1 << ord);
                            if (bf < base_frame || bf - base_frame >= seg) break;
                            if (tag[bf - base_frame] != ord) break;
                            unlink(bf - base_frame);
                            ord++;
                            frame &= ~((1 << ord) - 1);
                        end
                        idx = frame - base_frame;
                        if (idx < NPAGES) link(idx, ord, 1);
                        st = bpa_pkg::STAT_OK;
                        blk = idx;
                        fin = ord;
                    end
                end
            end
            exp_status.push_back(st[1:0]);
            exp_page.push_back(blk[11:0]);
            exp_order.push_back(fin[3:0]);
        endfunction

        function void check_response(logic [1:0] s, logic [11:0] p, logic [3:0] f);
            logic [1:0] es;
            logic [11:0] ep;
            logic [3:0] ef;
            if (exp_status.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response: %0d %0d %0d", s, p, f);
                return;
            end
            es = exp_status.pop_front();
            ep = exp_page.pop_front();
            ef = exp_order.pop_front();
            if (s !== es || p !== ep || f !== ef) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp st=%0d pg=%0d ord=%0d got st=%0d pg=%0d ord=%0d",
                             es, ep, ef, s, p, f);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic        i_action = 0;
    logic [3:0]  i_order = 0;
    logic [11:0] i_page_index = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [1:0]  o_status;
    logic [11:0] o_block_page;
    logic [3:0]  o_final_order;
    logic        i_cfg_we = 0;
    logic        i_cfg_idx = 0;
    logic [19:0] i_cfg_data = 0;

    buddy_page_allocator_unit u_top (.*);

    always #10 i_clk = ~i_clk;

    buddy_board board = new();
    int send_idle_pct = 0;   // chance of a gap before each request transfer
    int recv_stall_pct = 0;  // chance of ready low on any cycle

    // receiver: random stalls, checks every response transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                board.check_response(o_status, o_block_page, o_final_order);
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(logic act, logic [3:0] ord, logic [11:0] pidx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_action <= act;
        i_order <= ord;
        i_page_index <= pidx;
        // hold until the transfer edge
        do @(posedge i_clk); while (!o_ready);
        board.note_request(act, ord, pidx);
    endtask

    // wait for every response, then a margin so the engine is truly idle
    task automatic drain();
        i_valid <= 0;
        while (board.exp_status.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [19:0] v);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        board.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    // mostly plausible traffic: allocs at small orders, releases of aligned
    // blocks inside the segment, with some junk orders and wild indices
    task automatic random_phase(int n, int pcount);
        int r, ord, sz;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            ord = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(4);
            if (r < 35) begin
                send_request(bpa_pkg::ACT_ALLOC, 4'(ord), 12'($urandom));
            end else if (r < 90) begin
                sz = 1 << (ord < 11 ? ord : 0);
                send_request(bpa_pkg::ACT_RELEASE, 4'(ord),
                             12'(($urandom_range(pcount > 0 ? pcount : 1) / sz) * sz));
            end else begin
                send_request(bpa_pkg::ACT_RELEASE, 4'($urandom), 12'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed part: nothing free, bad order, out of segment, double release
        send_request(bpa_pkg::ACT_ALLOC, 4'd0, 12'd0);
        send_request(bpa_pkg::ACT_ALLOC, 4'd15, 12'hfff);
        send_request(bpa_pkg::ACT_RELEASE, 4'd11, 12'd0);
        send_request(bpa_pkg::ACT_RELEASE, 4'd15, 12'hfff);
        send_request(bpa_pkg::ACT_RELEASE, 4'd10, 12'hc00);   // top block of the segment
        send_request(bpa_pkg::ACT_RELEASE, 4'd10, 12'hc01);   // release inside it runs past the segment
        send_request(bpa_pkg::ACT_RELEASE, 4'd0, 12'hfff);    // overlaps a listed block
        send_request(bpa_pkg::ACT_RELEASE, 4'd1, 12'hfff);    // runs past the segment
        send_request(bpa_pkg::ACT_ALLOC, 4'd0, 12'd0);        // served from the order-0 list
        send_request(bpa_pkg::ACT_ALLOC, 4'd10, 12'd0);
        send_request(bpa_pkg::ACT_RELEASE, 4'd0, 12'hc00);
        send_request(bpa_pkg::ACT_RELEASE, 4'd0, 12'hc01);    // merges with its buddy
        send_request(bpa_pkg::ACT_ALLOC, 4'd1, 12'd0);
        send_request(bpa_pkg::ACT_ALLOC, 4'd10, 12'd0);
        drain();

        // odd base and short segment make buddies fall outside it
        write_reg(bpa_pkg::CFG_BASE, 20'hfffff);
        write_reg(bpa_pkg::CFG_PCNT, 20'd37);
        send_request(bpa_pkg::ACT_RELEASE, 4'd0, 12'd0);
        send_request(bpa_pkg::ACT_RELEASE, 4'd0, 12'd1);
        send_request(bpa_pkg::ACT_RELEASE, 4'd2, 12'd32);
        send_request(bpa_pkg::ACT_RELEASE, 4'd3, 12'd32);
        send_request(bpa_pkg::ACT_ALLOC, 4'd0, 12'd0);
        drain();

        send_idle_pct = 0;  recv_stall_pct = 0;
        random_phase(350, 37);
        drain();

        write_reg(bpa_pkg::CFG_BASE, 20'h00003);
        write_reg(bpa_pkg::CFG_PCNT, 20'd0);
        send_idle_pct = 67; recv_stall_pct = 0;
        random_phase(100, 4);
        drain();

        write_reg(bpa_pkg::CFG_BASE, 20'h12340);
        write_reg(bpa_pkg::CFG_PCNT, 20'd200);
        send_idle_pct = 0;  recv_stall_pct = 67;
        random_phase(350, 200);
        drain();

        write_reg(bpa_pkg::CFG_BASE, 20'h0);
        write_reg(bpa_pkg::CFG_PCNT, 20'h1fff);  // above PAGES acts as PAGES
        send_idle_pct = 17; recv_stall_pct = 17;
        random_phase(350, 4096);
        drain();

        write_reg(bpa_pkg::CFG_BASE, 20'h00005);
        write_reg(bpa_pkg::CFG_PCNT, 20'd64);
        send_idle_pct = 0;  recv_stall_pct = 0;
        random_phase(250, 64);
        drain();

        if (board.errors == 0 && board.exp_status.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("FAILURE");
        $finish;
    end
endmodule
